FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the store design file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    `ASSERT_AT(label, clk, rst_n, !(expr), msg)

`endif

FILE: design/atapio_pkg.sv
// ----------------------------------------------------------------------------
// atapio_pkg
// shared constants and types of the ata pio lba28 disk device
// ----------------------------------------------------------------------------
package atapio_pkg;

    localparam int DISK_SECTORS_DEF = 64;
    localparam int WORDS_PER_SECTOR = 256;
    localparam int WORD_IDX_W       = 8;
    localparam int LBA_W            = 28;
    localparam int COUNT_W          = 9;
    localparam int DATA_W           = 16;
    localparam int BYTE_W           = 8;
    localparam int DEV_BIT          = 4;

    localparam logic [COUNT_W-1:0] MAX_SECTOR_COUNT = 9'd256;

    // register offsets
    localparam logic [2:0] REG_DATA    = 3'd0;
    localparam logic [2:0] REG_ERROR   = 3'd1;
    localparam logic [2:0] REG_COUNT   = 3'd2;
    localparam logic [2:0] REG_LBA_LO  = 3'd3;
    localparam logic [2:0] REG_LBA_MID = 3'd4;
    localparam logic [2:0] REG_LBA_HI  = 3'd5;
    localparam logic [2:0] REG_DRIVE   = 3'd6;
    localparam logic [2:0] REG_STATUS  = 3'd7;

    // commands
    localparam logic [7:0] CMD_READ_SECTORS  = 8'h20;
    localparam logic [7:0] CMD_WRITE_SECTORS = 8'h30;
    localparam logic [7:0] CMD_FLUSH_CACHE   = 8'hE7;

    // error codes
    localparam logic [7:0] ERR_IDNF = 8'h10;
    localparam logic [7:0] ERR_ABRT = 8'h04;

    // status bits
    localparam logic [7:0] STS_DRDY = 8'h40;
    localparam logic [7:0] STS_DRQ  = 8'h08;
    localparam logic [7:0] STS_ERR  = 8'h01;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

endpackage

FILE: design/atapio_store.sv
// ----------------------------------------------------------------------------
// atapio_store
// sector word store with a registered read and a clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atapio_store #(
    parameter int DISK_SECTORS = atapio_pkg::DISK_SECTORS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  atapio_pkg::t_mem_ctl              i_ctl,
    input  logic [$clog2(DISK_SECTORS)+atapio_pkg::WORD_IDX_W-1:0] i_addr,
    input  logic [atapio_pkg::DATA_W-1:0]     i_wdata,
    output logic [atapio_pkg::DATA_W-1:0]     o_rdata,
    output logic                              o_clearing
);
    import atapio_pkg::*;

    localparam int ADDR_W = $clog2(DISK_SECTORS) + WORD_IDX_W;
    localparam int DEPTH  = DISK_SECTORS * WORDS_PER_SECTOR;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic              r_clearing;
    logic              n_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] n_clr_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;

    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    assign wr_en   = r_clearing || i_ctl.wr;
    assign wr_addr = r_clearing ? r_clr_addr : i_addr;
    assign wr_data = r_clearing ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

    `ASSERT_NEVER(a_no_access_in_clear, i_clk, i_rst_n, r_clearing && (i_ctl.rd || i_ctl.wr), "store accessed during clear")
    `ASSERT_NEVER(a_rd_wr_exclusive, i_clk, i_rst_n, i_ctl.rd && i_ctl.wr, "store read and write in one beat")
    `ASSERT_AT(a_clear_complete, i_clk, i_rst_n, $fell(r_clearing) |-> $past(r_clr_addr) == LAST_ADDR, "clear pass ended early")

endmodule

FILE: design/atapio_taskfile.sv
// ----------------------------------------------------------------------------
// atapio_taskfile
// task file registers, command decode and transfer pointer
// ----------------------------------------------------------------------------
module atapio_taskfile #(
    parameter int DISK_SECTORS = atapio_pkg::DISK_SECTORS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_wdata,
    input  logic                              i_accept,
    input  logic                              i_op,
    input  logic [2:0]                        i_reg_offset,
    input  logic [atapio_pkg::DATA_W-1:0]     i_write_data,
    output atapio_pkg::t_mem_ctl              o_ctl,
    output logic [$clog2(DISK_SECTORS)+atapio_pkg::WORD_IDX_W-1:0] o_addr,
    output logic [atapio_pkg::DATA_W-1:0]     o_wdata,
    output logic                              o_use_mem,
    output logic [atapio_pkg::DATA_W-1:0]     o_value
);
    import atapio_pkg::*;

    localparam int SECT_W = (DISK_SECTORS > 1) ? $clog2(DISK_SECTORS) : 1;
    localparam int ADDR_W = $clog2(DISK_SECTORS) + WORD_IDX_W;
    localparam logic [LBA_W:0] LIMIT = (LBA_W+1)'(DISK_SECTORS);

    logic                  r_dev_sel;
    logic [BYTE_W-1:0]     r_count, n_count;
    logic [BYTE_W-1:0]     r_lba_lo, n_lba_lo;
    logic [BYTE_W-1:0]     r_lba_mid, n_lba_mid;
    logic [BYTE_W-1:0]     r_lba_hi, n_lba_hi;
    logic [BYTE_W-1:0]     r_drive, n_drive;
    logic [BYTE_W-1:0]     r_err_reg, n_err_reg;
    logic                  r_drq, n_drq;
    logic                  r_err, n_err;
    logic                  r_dir_wr, n_dir_wr;
    logic [WORD_IDX_W-1:0] r_word, n_word;
    logic [SECT_W-1:0]     r_sector, n_sector;
    logic [COUNT_W-1:0]    r_remain, n_remain;

    logic                  selected;
    logic [BYTE_W-1:0]     wbyte;
    logic [LBA_W-1:0]      lba;
    logic [COUNT_W-1:0]    n_sectors;
    logic [LBA_W:0]        lba_end;
    logic                  advance;
    logic [COUNT_W-1:0]    remain_dec;

    assign wbyte     = i_write_data[BYTE_W-1:0];
    assign selected  = (r_drive[DEV_BIT] == r_dev_sel);
    assign lba       = {r_drive[3:0], r_lba_hi, r_lba_mid, r_lba_lo};
    assign n_sectors = (r_count == '0) ? MAX_SECTOR_COUNT : COUNT_W'(r_count);
    assign lba_end   = {1'b0, lba} + (LBA_W+1)'(n_sectors);
    assign remain_dec = r_remain - COUNT_W'(r_remain != '0);
    assign o_addr    = ADDR_W'({r_sector, r_word});
    assign o_wdata   = i_write_data;

    always_comb begin
        n_count   = r_count;
        n_lba_lo  = r_lba_lo;
        n_lba_mid = r_lba_mid;
        n_lba_hi  = r_lba_hi;
        n_drive   = r_drive;
        n_err_reg = r_err_reg;
        n_drq     = r_drq;
        n_err     = r_err;
        n_dir_wr  = r_dir_wr;
        n_word    = r_word;
        n_sector  = r_sector;
        n_remain  = r_remain;
        o_ctl     = '0;
        o_use_mem = 1'b0;
        o_value   = '0;
        advance   = 1'b0;

        if (i_accept) begin
            if (i_op && i_reg_offset == REG_DRIVE) begin
                n_drive = wbyte;
            end else if (selected && i_op) begin
                unique case (i_reg_offset)
                    REG_DATA: begin
                        if (r_drq && r_dir_wr) begin
                            o_ctl.wr = 1'b1;
                            advance  = 1'b1;
                        end
                    end
                    REG_COUNT:   n_count   = wbyte;
                    REG_LBA_LO:  n_lba_lo  = wbyte;
                    REG_LBA_MID: n_lba_mid = wbyte;
                    REG_LBA_HI:  n_lba_hi  = wbyte;
                    REG_STATUS: begin
                        n_err     = 1'b0;
                        n_err_reg = '0;
                        n_drq     = 1'b0;
                        if (wbyte == CMD_READ_SECTORS || wbyte == CMD_WRITE_SECTORS) begin
                            if (lba_end > LIMIT) begin
                                n_err     = 1'b1;
                                n_err_reg = ERR_IDNF;
                            end else begin
                                n_sector = lba[SECT_W-1:0];
                                n_remain = n_sectors;
                                n_word   = '0;
                                n_dir_wr = (wbyte == CMD_WRITE_SECTORS);
                                n_drq    = 1'b1;
                            end
                        end else if (wbyte != CMD_FLUSH_CACHE) begin
                            n_err     = 1'b1;
                            n_err_reg = ERR_ABRT;
                        end
                    end
                    default: ;
                endcase
            end else if (selected) begin
                unique case (i_reg_offset)
                    REG_DATA: begin
                        if (r_drq && !r_dir_wr) begin
                            o_ctl.rd  = 1'b1;
                            o_use_mem = 1'b1;
                            advance   = 1'b1;
                        end
                    end
                    REG_ERROR:   o_value = DATA_W'(r_err_reg);
                    REG_COUNT:   o_value = DATA_W'(r_count);
                    REG_LBA_LO:  o_value = DATA_W'(r_lba_lo);
                    REG_LBA_MID: o_value = DATA_W'(r_lba_mid);
                    REG_LBA_HI:  o_value = DATA_W'(r_lba_hi);
                    REG_DRIVE:   o_value = DATA_W'(r_drive);
                    default: begin
                        o_value = DATA_W'(STS_DRDY | (r_drq ? STS_DRQ : 8'h00)
                                          | (r_err ? STS_ERR : 8'h00));
                    end
                endcase
            end
        end

        // step the transfer pointer by one word; at a sector's end move to the next sector and drop DRQ after the last
        if (advance) begin
            n_word = r_word + 1'b1;
            if (r_word == WORD_IDX_W'(WORDS_PER_SECTOR - 1)) begin
                n_sector = r_sector + 1'b1;
                n_remain = remain_dec;
                if (remain_dec == '0) begin
                    n_drq = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_sel <= 1'b1;
            r_count   <= '0;
            r_lba_lo  <= '0;
            r_lba_mid <= '0;
            r_lba_hi  <= '0;
            r_drive   <= '0;
            r_err_reg <= '0;
            r_drq     <= 1'b0;
            r_err     <= 1'b0;
            r_dir_wr  <= 1'b0;
            r_word    <= '0;
            r_sector  <= '0;
            r_remain  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_dev_sel <= i_cfg_wdata;
            end
            r_count   <= n_count;
            r_lba_lo  <= n_lba_lo;
            r_lba_mid <= n_lba_mid;
            r_lba_hi  <= n_lba_hi;
            r_drive   <= n_drive;
            r_err_reg <= n_err_reg;
            r_drq     <= n_drq;
            r_err     <= n_err;
            r_dir_wr  <= n_dir_wr;
            r_word    <= n_word;
            r_sector  <= n_sector;
            r_remain  <= n_remain;
        end
    end

endmodule

FILE: design/ata_pio_lba28_disk_device.sv
// ----------------------------------------------------------------------------
// ata_pio_lba28_disk_device
// device side of an ata pio lba28 task file with a sector word store
// ----------------------------------------------------------------------------
// One bus access beat is taken per clock and its read data beat passes
// through the s1 and output registers; the sustained rate is one beat per
// cycle, held up only by output side stall and the store clearing pass. Task
// file registers live in flops, sector words in a single-port store with a
// registered read, which a data port read reaches in the cycle after the
// beat is taken. After reset the store is cleared one word per cycle,
// DISK_SECTORS * 256 words (16384 by default), and no input beat is taken
// until that pass is done; the select register can be written at any time.
module ata_pio_lba28_disk_device #(
    parameter int DISK_SECTORS = atapio_pkg::DISK_SECTORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_op,
    input  logic [2:0]                    i_reg_offset,
    input  logic [atapio_pkg::DATA_W-1:0] i_write_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [atapio_pkg::DATA_W-1:0] o_read_data
);
    import atapio_pkg::*;

    localparam int ADDR_W = $clog2(DISK_SECTORS) + WORD_IDX_W;

    t_mem_ctl          mem_ctl;
    logic [ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0] mem_wdata;
    logic [DATA_W-1:0] mem_rdata;
    logic              clearing;
    logic              use_mem;
    logic [DATA_W-1:0] reg_value;
    logic              accept_in;
    logic              s1_adv;

    logic              r_s1_valid;
    logic              r_s1_mem;
    logic [DATA_W-1:0] r_s1_data;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = clearing || (r_s1_valid && !s1_adv);
    assign accept_in  = i_in_valid && !o_in_stall;

    atapio_taskfile #(
        .DISK_SECTORS(DISK_SECTORS)
    ) u_taskfile (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_accept     (accept_in),
        .i_op         (i_op),
        .i_reg_offset (i_reg_offset),
        .i_write_data (i_write_data),
        .o_ctl        (mem_ctl),
        .o_addr       (mem_addr),
        .o_wdata      (mem_wdata),
        .o_use_mem    (use_mem),
        .o_value      (reg_value)
    );

    atapio_store #(
        .DISK_SECTORS(DISK_SECTORS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mem_ctl),
        .i_addr     (mem_addr),
        .i_wdata    (mem_wdata),
        .o_rdata    (mem_rdata),
        .o_clearing (clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept_in) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_mem  <= use_mem;
            r_s1_data <= reg_value;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_data <= r_s1_mem ? mem_rdata : r_s1_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

endmodule

FILE: dv/tb_ata_pio_lba28_disk_device.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ata_pio_lba28_disk_device
// directed and random host bus accesses checked against a task file and sector store
// predictor, with random gaps on both sides and one long output hold-off
// ----------------------------------------------------------------------------
module tb_ata_pio_lba28_disk_device;
    import atapio_pkg::*;

    localparam int STORE_WORDS = DISK_SECTORS_DEF * WORDS_PER_SECTOR;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ACCESSES = 400;
    localparam logic [7:0] CMD_UNSUPPORTED = 8'hFF;

    typedef enum logic {
        BUS_READ  = 1'b0,
        BUS_WRITE = 1'b1
    } t_bus_op;

    typedef struct {
        bit          is_cfg;
        t_bus_op     op;
        logic [2:0]  offset;
        logic [15:0] wdata;
    } t_host_access;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_op = 1'b0;
    logic [2:0]  i_reg_offset = '0;
    logic [15:0] i_write_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_read_data;

    t_host_access host_access_q[$];
    logic [15:0]  read_data_q[$];
    int           n_queued = 0;
    int           n_mismatch = 0;
    int           beats_checked = 0;
    int           cycle_cnt = 0;
    int           gap_left = 0;
    int           burst_left = 0;
    int           stall_left = 0;
    bit           hold_off_done = 1'b0;

    // predicted device state
    logic [15:0] disk_img[STORE_WORDS];
    logic [7:0]  count_r = '0;
    logic [7:0]  lba_lo_r = '0;
    logic [7:0]  lba_mid_r = '0;
    logic [7:0]  lba_hi_r = '0;
    logic [7:0]  drive_r = '0;
    logic [7:0]  err_code_r = '0;
    logic        drq = 1'b0;
    logic        err_f = 1'b0;
    logic        wr_dir = 1'b0;
    int unsigned word_ptr = 0;
    int unsigned cur_sect = 0;
    int unsigned sect_left = 0;
    logic        sel_bit = 1'b1;

    ata_pio_lba28_disk_device u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_reg_offset (i_reg_offset),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void step_word();
        word_ptr++;
        if (word_ptr >= WORDS_PER_SECTOR) begin
            word_ptr = 0;
            cur_sect++;
            if (sect_left > 0)
                sect_left--;
            if (sect_left == 0)
                drq = 1'b0;
        end
    endfunction

    function automatic logic [15:0] task_file_access(logic op, logic [2:0] offset,
                                                     logic [15:0] wdata);
        logic [15:0] rdata;
        logic [7:0]  wbyte;
        int unsigned addr;
        int unsigned lba;
        int unsigned nsec;
        rdata = '0;
        wbyte = wdata[7:0];
        addr = cur_sect * WORDS_PER_SECTOR + word_ptr;
        if (op == BUS_WRITE && offset == REG_DRIVE) begin
            drive_r = wbyte;
            return '0;
        end
        if (drive_r[DEV_BIT] != sel_bit)
            return '0;
        if (op == BUS_WRITE) begin
            case (offset)
                REG_DATA: begin
                    if (drq && wr_dir) begin
                        if (addr < STORE_WORDS)
                            disk_img[addr] = wdata;
                        step_word();
                    end
                end
                REG_COUNT:   count_r = wbyte;
                REG_LBA_LO:  lba_lo_r = wbyte;
                REG_LBA_MID: lba_mid_r = wbyte;
                REG_LBA_HI:  lba_hi_r = wbyte;
                REG_STATUS: begin
                    err_f = 1'b0;
                    err_code_r = '0;
                    drq = 1'b0;
                    if (wbyte == CMD_READ_SECTORS || wbyte == CMD_WRITE_SECTORS) begin
                        lba = 32'({drive_r[3:0], lba_hi_r, lba_mid_r, lba_lo_r});
                        nsec = (count_r != 0) ? 32'(count_r) : 32'(MAX_SECTOR_COUNT);
                        if (lba >= DISK_SECTORS_DEF || nsec > DISK_SECTORS_DEF - lba) begin
                            err_f = 1'b1;
                            err_code_r = ERR_IDNF;
                        end else begin
                            cur_sect = lba;
                            sect_left = nsec;
                            word_ptr = 0;
                            wr_dir = (wbyte == CMD_WRITE_SECTORS);
                            drq = 1'b1;
                        end
                    end else if (wbyte != CMD_FLUSH_CACHE) begin
                        err_f = 1'b1;
                        err_code_r = ERR_ABRT;
                    end
                end
                default: ;
            endcase
        end else begin
            case (offset)
                REG_DATA: begin
                    if (drq && !wr_dir) begin
                        if (addr < STORE_WORDS)
                            rdata = disk_img[addr];
                        step_word();
                    end
                end
                REG_ERROR:   rdata = {8'h00, err_code_r};
                REG_COUNT:   rdata = {8'h00, count_r};
                REG_LBA_LO:  rdata = {8'h00, lba_lo_r};
                REG_LBA_MID: rdata = {8'h00, lba_mid_r};
                REG_LBA_HI:  rdata = {8'h00, lba_hi_r};
                REG_DRIVE:   rdata = {8'h00, drive_r};
                default: rdata = {8'h00, STS_DRDY | (drq ? STS_DRQ : 8'h00) |
                                         (err_f ? STS_ERR : 8'h00)};
            endcase
        end
        return rdata;
    endfunction

    function automatic int next_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            burst_left = $urandom_range(30, 100);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 99)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_access(t_bus_op op, logic [2:0] offset, logic [15:0] wdata);
        t_host_access a;
        a.is_cfg = 1'b0;
        a.op = op;
        a.offset = offset;
        a.wdata = wdata;
        host_access_q.push_back(a);
        n_queued++;
    endtask

    task automatic push_cfg(logic sel);
        t_host_access a;
        a.is_cfg = 1'b1;
        a.op = BUS_WRITE;
        a.offset = '0;
        a.wdata = {15'd0, sel};
        host_access_q.push_back(a);
    endtask

    task automatic queue_random_sequence(logic sel, bit force_long);
        int          kind;
        int          n_words;
        int          r;
        logic [7:0]  drv;
        logic [7:0]  cnt;
        logic [7:0]  lba_lo;
        logic [7:0]  cmd;
        t_bus_op     dir;
        logic [7:0]  lba_pick[6];
        lba_pick = '{8'd0, 8'd1, 8'd2, 8'd61, 8'd62, 8'd63};
        kind = force_long ? 0 : $urandom_range(0, 9);
        if (kind <= 5) begin
            drv = {3'($urandom), sel,
                   ($urandom_range(0, 9) == 0 && !force_long) ? 4'($urandom) : 4'h0};
            push_access(BUS_WRITE, REG_DRIVE, {8'($urandom), drv});
            r = $urandom_range(0, 9);
            if (force_long)
                cnt = 8'd2;
            else if (r == 0)
                cnt = 8'd0;
            else if (r == 1)
                cnt = 8'($urandom);
            else
                cnt = 8'($urandom_range(1, 3));
            push_access(BUS_WRITE, REG_COUNT, {8'($urandom), cnt});
            if (force_long)
                lba_lo = 8'd0;
            else if ($urandom_range(0, 7) == 0)
                lba_lo = 8'($urandom);
            else
                lba_lo = lba_pick[$urandom_range(0, 5)];
            push_access(BUS_WRITE, REG_LBA_LO, {8'($urandom), lba_lo});
            push_access(BUS_WRITE, REG_LBA_MID,
                        {8'($urandom), ($urandom_range(0, 9) == 0 && !force_long) ?
                                       8'($urandom) : 8'h00});
            push_access(BUS_WRITE, REG_LBA_HI,
                        {8'($urandom), ($urandom_range(0, 9) == 0 && !force_long) ?
                                       8'($urandom) : 8'h00});
            if ($urandom_range(0, 3) == 0)
                push_access(BUS_READ, 3'($urandom_range(1, 6)), 16'($urandom));
            dir = (force_long || $urandom_range(0, 1) == 1) ? BUS_WRITE : BUS_READ;
            cmd = (dir == BUS_WRITE) ? CMD_WRITE_SECTORS : CMD_READ_SECTORS;
            push_access(BUS_WRITE, REG_STATUS, {8'($urandom), cmd});
            if (force_long || $urandom_range(0, 11) == 0)
                n_words = $urandom_range(256, 300);
            else
                n_words = $urandom_range(1, 12);
            for (int i = 0; i < n_words; i++) begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    push_access(BUS_READ, REG_STATUS, 16'($urandom));
                else if (r == 1)
                    push_access(dir == BUS_WRITE ? BUS_READ : BUS_WRITE, REG_DATA,
                                16'($urandom));
                else
                    push_access(dir, REG_DATA, 16'($urandom));
            end
            if ($urandom_range(0, 2) == 0) begin
                push_access(BUS_READ, REG_STATUS, 16'($urandom));
                push_access(BUS_READ, REG_ERROR, 16'($urandom));
            end
        end else if (kind <= 7) begin
            n_words = $urandom_range(1, 6);
            for (int i = 0; i < n_words; i++)
                push_access(t_bus_op'($urandom_range(0, 1)), 3'($urandom), 16'($urandom));
        end else if (kind == 8) begin
            cmd = ($urandom_range(0, 1) == 1) ? CMD_FLUSH_CACHE : 8'($urandom);
            push_access(BUS_WRITE, REG_STATUS, {8'($urandom), cmd});
            push_access(BUS_READ, REG_STATUS, 16'($urandom));
            push_access(BUS_READ, REG_ERROR, 16'($urandom));
        end else begin
            push_access(BUS_WRITE, REG_DRIVE, {8'($urandom), 3'($urandom), ~sel, 4'($urandom)});
            n_words = $urandom_range(1, 4);
            for (int i = 0; i < n_words; i++)
                push_access(t_bus_op'($urandom_range(0, 1)), 3'($urandom), 16'($urandom));
            push_access(BUS_WRITE, REG_DRIVE, {8'($urandom), 3'($urandom), sel, 4'h0});
        end
    endtask

    initial begin : stimulus
        int base;
        logic sel;
        for (int i = 0; i < STORE_WORDS; i++)
            disk_img[i] = '0;

        push_cfg(1'b1);
        // unselected device, then error, abort and flush handling
        push_access(BUS_READ,  REG_STATUS, 16'h0000);
        push_access(BUS_WRITE, REG_DRIVE,  16'hFFF0);
        push_access(BUS_READ,  REG_STATUS, 16'hFFFF);
        push_access(BUS_WRITE, REG_COUNT,  16'h0000);
        push_access(BUS_WRITE, REG_STATUS, {8'h00, CMD_READ_SECTORS});
        push_access(BUS_READ,  REG_STATUS, 16'h0000);
        push_access(BUS_READ,  REG_ERROR,  16'h0000);
        push_access(BUS_WRITE, REG_STATUS, {8'hFF, CMD_UNSUPPORTED});
        push_access(BUS_READ,  REG_ERROR,  16'h0000);
        push_access(BUS_WRITE, REG_ERROR,  16'hFFFF);
        push_access(BUS_WRITE, REG_STATUS, {8'h00, CMD_FLUSH_CACHE});
        push_access(BUS_READ,  REG_STATUS, 16'h0000);
        // last sector write, wrong direction access, deselect in mid transfer, then a read and an out of range lba
        push_access(BUS_WRITE, REG_COUNT,  16'hFF01);
        push_access(BUS_WRITE, REG_LBA_LO, 16'h003F);
        push_access(BUS_WRITE, REG_STATUS, {8'h00, CMD_WRITE_SECTORS});
        push_access(BUS_WRITE, REG_DATA,   16'hFFFF);
        push_access(BUS_READ,  REG_DATA,   16'h0000);
        push_access(BUS_WRITE, REG_DATA,   16'h0000);
        push_access(BUS_WRITE, REG_DRIVE,  16'h00E0);
        push_access(BUS_READ,  REG_COUNT,  16'h0000);
        push_access(BUS_WRITE, REG_DRIVE,  16'h00F0);
        push_access(BUS_READ,  REG_COUNT,  16'h0000);
        push_access(BUS_WRITE, REG_STATUS, {8'h00, CMD_READ_SECTORS});
        push_access(BUS_READ,  REG_DATA,   16'h0000);
        push_access(BUS_WRITE, REG_LBA_HI, 16'hFFFF);
        push_access(BUS_WRITE, REG_STATUS, {8'h00, CMD_READ_SECTORS});

        base = n_queued;
        for (int phase = 0; phase < 4; phase++) begin
            sel = (phase % 2 == 1);
            push_cfg(sel);
            if (phase == 0)
                queue_random_sequence(sel, 1'b1);
            while (n_queued < base + (RANDOM_ACCESSES / 4) * (phase + 1))
                queue_random_sequence(sel, 1'b0);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (host_access_q.size() != 0 || i_in_valid)
            @(negedge i_clk);
        while (read_data_q.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (n_mismatch == 0)
            $display("tb_ata_pio_lba28_disk_device: PASS");
        else
            $display("tb_ata_pio_lba28_disk_device: FAIL");
        $finish;
    end

    always @(posedge i_clk) begin : drive_beats
        t_host_access nxt;
        logic valid_n;
        logic cfg_we_n;
        if (i_rst_n) begin
            valid_n = i_in_valid;
            cfg_we_n = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                read_data_q.push_back(task_file_access(i_op, i_reg_offset, i_write_data));
                valid_n = 1'b0;
            end
            if (!valid_n) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (host_access_q.size() != 0) begin
                    nxt = host_access_q[0];
                    if (!nxt.is_cfg) begin
                        void'(host_access_q.pop_front());
                        valid_n = 1'b1;
                        i_op <= nxt.op;
                        i_reg_offset <= nxt.offset;
                        i_write_data <= nxt.wdata;
                        gap_left = next_gap();
                    end else if (read_data_q.size() == 0) begin
                        void'(host_access_q.pop_front());
                        cfg_we_n = 1'b1;
                        i_cfg_wdata <= nxt.wdata[0];
                        sel_bit = nxt.wdata[0];
                        gap_left = next_gap();
                    end
                end
            end
            i_in_valid <= valid_n;
            i_cfg_we <= cfg_we_n;
        end
    end

    always @(posedge i_clk) begin : out_stall_gen
        int r;
        if (stall_left > 0) begin
            stall_left--;
        end else if (!hold_off_done && beats_checked >= 60) begin
            // long hold-off so the device backs up into its input
            i_out_stall <= 1'b1;
            stall_left = 400;
            hold_off_done = 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                i_out_stall <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end else if (r < 65) begin
                i_out_stall <= 1'b0;
                stall_left = $urandom_range(40, 120);
            end else if (r < 95) begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b1;
                stall_left = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin : check_read_data
        logic [15:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (read_data_q.size() == 0) begin
                $display("%0t: read_data beat with none pending: expected none, actual %h",
                         $time, o_read_data);
                n_mismatch++;
            end else begin
                want = read_data_q.pop_front();
                beats_checked++;
                if (o_read_data !== want) begin
                    $display("%0t: read_data mismatch: expected %h, actual %h",
                             $time, want, o_read_data);
                    n_mismatch++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_ata_pio_lba28_disk_device: FAIL");
            $finish;
        end
    end

endmodule
